@@ hdl/fmpq_pkg.sv @@
package fmpq_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int ID_W = 32;
  localparam int AMT_W = 20;

  localparam logic [1:0] OP_ARRIVE  = 2'd0;
  localparam logic [1:0] OP_OLDEST  = 2'd1;
  localparam logic [1:0] OP_HIGHEST = 2'd2;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_SERVED  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amount;
  } entry_t;

  // one entry seen by the compare unit during a scan
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [AMT_W-1:0] amount;
    logic [ID_W-1:0]  id;
    ptr_t             addr;
    ptr_t             pos;
  } scan_in_t;

  typedef struct packed {
    logic [AMT_W-1:0] amount;
    logic [ID_W-1:0]  id;
    ptr_t             addr;
    ptr_t             pos;
  } scan_best_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(POOL_DEPTH - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_t r;
    if (p == '0) r = ptr_t'(POOL_DEPTH - 1);
    else r = p - ptr_t'(1);
    return r;
  endfunction

endpackage

@@ hdl/fmpq_scan.sv @@
module fmpq_scan (
  input  logic                clk,
  input  fmpq_pkg::scan_in_t   sample,
  output fmpq_pkg::scan_best_t best
);
  import fmpq_pkg::*;

  // strict greater keeps the oldest among equal amounts
  always_ff @(posedge clk) begin
    if (sample.valid && (sample.first || sample.amount > best.amount)) begin
      best.amount <= sample.amount;
      best.id     <= sample.id;
      best.addr   <= sample.addr;
      best.pos    <= sample.pos;
    end
  end

endmodule

@@ hdl/fifo_and_max_priority_dual_queue_core.sv @@
// waiting pool with two service orders. each beat on start/opcode/amount is one
// command: arrival stores amount with the next sequence id (ids wrap and skip
// zero), serve oldest removes the longest waiting entry, serve highest removes
// the entry with the largest amount, oldest first among equals. every command
// gives exactly one result beat, a one-cycle pulse on done with served_id and
// status; the receiver cannot stall, so it must take the beat in that cycle.
// a command is taken when start is high and busy is low. arrival and any serve
// of an empty pool give done in the cycle after acceptance and busy never
// rises; serve oldest reads the head entry in S_OLDEST and then answers; serve
// highest passes through S_SCAN, S_PICK and, when entries younger than the
// chosen one remain, S_SHIFT. the single read port of the entry memory sets
// this order: the maximum search reads one entry a cycle through a single
// comparator, then the younger entries are copied down one slot a cycle to close the gap.
module fifo_and_max_priority_dual_queue_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic [fmpq_pkg::AMT_W-1:0] amount,
  output logic                     done,
  output logic [fmpq_pkg::ID_W-1:0]  served_id,
  output logic [1:0]               status
);
  import fmpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OLDEST,
    S_SCAN,
    S_PICK,
    S_SHIFT
  } state_t;

  state_t state;

  // circular buffer: head is the oldest entry, tail the next free slot
  ptr_t            head;
  ptr_t            tail;
  cnt_t            count;
  logic [ID_W-1:0] next_id;

  // scan and shift bookkeeping
  ptr_t scan_pos;
  ptr_t scan_addr;
  ptr_t src;
  ptr_t dst;
  cnt_t shift_left;
  cnt_t moves;

  // entry memory, one write and one registered read per cycle
  entry_t mem [POOL_DEPTH];
  entry_t rd_data;
  ptr_t   rd_addr;
  logic   we;
  ptr_t   wa;
  entry_t wd;

  logic            accept;
  logic            scan_last;
  logic [ID_W-1:0] id_inc;

  scan_in_t   sample;
  scan_best_t best;

  fmpq_scan u_scan (
    .clk    (clk),
    .sample (sample),
    .best   (best)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign scan_last = (cnt_t'(scan_pos) == count - cnt_t'(1));
  assign moves     = count - cnt_t'(1) - cnt_t'(best.pos);
  assign id_inc    = next_id + ID_W'(1);

  // compare unit sees the entry whose read came back this cycle
  always_comb begin
    sample.valid  = (state == S_SCAN);
    sample.first  = (scan_pos == '0);
    sample.amount = rd_data.amount;
    sample.id     = rd_data.id;
    sample.addr   = scan_addr;
    sample.pos    = scan_pos;
  end

  // memory port control
  always_comb begin
    rd_addr = head;
    we      = 1'b0;
    wa      = tail;
    wd      = '{id: next_id, amount: amount};
    unique case (state)
      S_IDLE: begin
        rd_addr = head;
        // store an arrival straight away when there is room
        we = accept && (opcode == OP_ARRIVE) && (count != cnt_t'(POOL_DEPTH));
      end
      S_OLDEST: rd_addr = head;
      S_SCAN:   rd_addr = ptr_inc(scan_addr);
      S_PICK:   rd_addr = ptr_inc(best.addr);
      S_SHIFT: begin
        rd_addr = ptr_inc(src);
        we      = 1'b1;
        wa      = dst;
        wd      = rd_data;
      end
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  // sequencer with registered result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      next_id <= ID_W'(1);
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_ARRIVE: begin
                done <= 1'b1;
                if (count == cnt_t'(POOL_DEPTH)) begin
                  served_id <= '0;
                  status    <= ST_FULL;
                end else begin
                  served_id <= next_id;
                  status    <= ST_STORED;
                  tail      <= ptr_inc(tail);
                  count     <= count + cnt_t'(1);
                  // id zero is reserved for "no entry"
                  next_id   <= (id_inc == '0) ? ID_W'(1) : id_inc;
                end
              end
              OP_OLDEST: begin
                if (count == '0) begin
                  done      <= 1'b1;
                  served_id <= '0;
                  status    <= ST_EMPTY;
                end else begin
                  state <= S_OLDEST;
                end
              end
              default: begin
                // highest amount; opcode three lands here as well
                if (count == '0) begin
                  done      <= 1'b1;
                  served_id <= '0;
                  status    <= ST_EMPTY;
                end else begin
                  scan_pos  <= '0;
                  scan_addr <= head;
                  state     <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_OLDEST: begin
          done      <= 1'b1;
          served_id <= rd_data.id;
          status    <= ST_SERVED;
          head      <= ptr_inc(head);
          count     <= count - cnt_t'(1);
          state     <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_PICK;
          end else begin
            scan_pos  <= scan_pos + ptr_t'(1);
            scan_addr <= ptr_inc(scan_addr);
          end
        end
        S_PICK: begin
          if (moves == '0) begin
            // chosen entry is the youngest, nothing to close up
            done      <= 1'b1;
            served_id <= best.id;
            status    <= ST_SERVED;
            tail      <= ptr_dec(tail);
            count     <= count - cnt_t'(1);
            state     <= S_IDLE;
          end else begin
            dst        <= best.addr;
            src        <= ptr_inc(best.addr);
            shift_left <= moves;
            state      <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (shift_left == cnt_t'(1)) begin
            done      <= 1'b1;
            served_id <= best.id;
            status    <= ST_SERVED;
            tail      <= ptr_dec(tail);
            count     <= count - cnt_t'(1);
            state     <= S_IDLE;
          end else begin
            dst        <= src;
            src        <= ptr_inc(src);
            shift_left <= shift_left - cnt_t'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(POOL_DEPTH))
    else $error("pool count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + cnt_t'(1)) ||
    (count + cnt_t'(1) == $past(count)))
    else $error("pool count moved by more than one");

  a_arrive_quick: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_ARRIVE) |=> (done && (status == ST_STORED || status == ST_FULL)))
    else $error("arrival not answered in one cycle");

  a_empty_serve: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode != OP_ARRIVE && count == '0) |=>
      (done && status == ST_EMPTY && served_id == '0))
    else $error("serve of empty pool not flagged");

  a_served_id: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_SERVED || status == ST_STORED)) |-> (served_id != '0))
    else $error("zero id on a served or stored beat");
`endif

endmodule

@@ verif/fmpq_checker.sv @@
module fmpq_checker
  import fmpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        opcode,
  input  logic [AMT_W-1:0]  amount,
  input  logic              done,
  input  logic [ID_W-1:0]   served_id,
  input  logic [1:0]        status,
  output int                errors,
  output int                replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      status;
  } reply_t;

  entry_t          waiting_pool[$];   // oldest at index 0
  reply_t          pending_replies[$];
  logic [ID_W-1:0] next_seq_id;
  int              fail_count = 0;

  // updates the pool image and returns the reply the block owes for this command
  function automatic reply_t apply_command(input logic [1:0] op,
                                           input logic [AMT_W-1:0] amt);
    reply_t r;
    entry_t e;
    int     pick;
    r.id = '0;
    if (op == OP_ARRIVE) begin
      if (waiting_pool.size() >= POOL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.id = next_seq_id;
        e.amount = amt;
        waiting_pool.push_back(e);
        r.id = next_seq_id;
        r.status = ST_STORED;
        next_seq_id = next_seq_id + 1'b1;
        if (next_seq_id == '0) next_seq_id = 1;
      end
    end else if (waiting_pool.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pick = 0;
      // anything but serve oldest searches for the largest amount
      if (op != OP_OLDEST) begin
        for (int i = 1; i < waiting_pool.size(); i++)
          if (waiting_pool[i].amount > waiting_pool[pick].amount) pick = i;
      end
      r.id = waiting_pool[pick].id;
      r.status = ST_SERVED;
      waiting_pool.delete(pick);
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      waiting_pool.delete();
      pending_replies.delete();
      next_seq_id = 1;
    end else begin
      // result beat belongs to an earlier command, so compare before predicting
      if (done) begin
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("unexpected result: served_id %0h status %0d",
                                 served_id, status));
        end else begin
          want = pending_replies.pop_front();
          if (served_id !== want.id || status !== want.status)
            note_failure($sformatf("result mismatch: served_id %0h/%0h status %0d/%0d",
                                   want.id, served_id, want.status, status));
        end
      end
      if (start && !busy) pending_replies.push_back(apply_command(opcode, amount));
    end
    errors <= fail_count;
    replies_due <= pending_replies.size();
  end

endmodule

@@ verif/testbench.sv @@
module testbench;
  import fmpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // only bit 1 of the opcode picks the serve order, so three is serve highest too
  localparam logic [1:0] OP_HIGHEST_ALIAS = 2'd3;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;
  localparam int ITEM_TARGET  = 450;
  // slowest serve is a full scan plus a full shift of the pool
  localparam int DRAIN_CYCLES = 2 * POOL_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400_000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       opcode;
  logic [AMT_W-1:0] amount;
  logic             done;
  logic [ID_W-1:0]  served_id;
  logic [1:0]       status;

  int errors;
  int replies_due;
  int sent = 0;
  bit steady = 1'b0;   // no idle gaps while set

  fifo_and_max_priority_dual_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .amount    (amount),
    .done      (done),
    .served_id (served_id),
    .status    (status)
  );

  fmpq_checker pool_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .amount      (amount),
    .done        (done),
    .served_id   (served_id),
    .status      (status),
    .errors      (errors),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or never raises done
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // one command beat; start stays high across back-to-back beats so it
  // never gets two assignments in one step
  task automatic issue(input logic [1:0] op, input logic [AMT_W-1:0] amt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    amount <= amt;
    // busy read right after the edge is the value the block saw at that edge
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // mix of wide random amounts, a narrow band that forces ties, and the extremes
  function automatic logic [AMT_W-1:0] pick_amount();
    logic [AMT_W-1:0] a;
    case ($urandom_range(0, 3))
      0: a = AMT_W'($urandom_range(0, 7));
      1: a = $urandom_range(0, 1) ? AMT_MAX : '0;
      default: a = AMT_W'($urandom());
    endcase
    return a;
  endfunction

  initial begin
    int arrive_pct;
    int phase_len;
    int roll;
    bit first_phase;
    logic [1:0] op;

    rst <= 1'b1;
    start <= 1'b0;
    opcode <= OP_ARRIVE;
    amount <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // serves on an empty pool, every serve encoding
    issue(OP_OLDEST, '0);
    issue(OP_HIGHEST, AMT_MAX);
    issue(OP_HIGHEST_ALIAS, '0);
    // extremes and ties: two maxima, two fives
    issue(OP_ARRIVE, '0);
    issue(OP_ARRIVE, AMT_MAX);
    issue(OP_ARRIVE, 20'd5);
    issue(OP_ARRIVE, AMT_MAX);
    issue(OP_ARRIVE, 20'd5);
    // highest picks the older of equal maxima, then the younger one
    issue(OP_HIGHEST, '0);
    steady = 1'b1;
    issue(OP_HIGHEST_ALIAS, '0);
    // tie on five, older wins
    issue(OP_HIGHEST, '0);
    issue(OP_OLDEST, AMT_MAX);
    steady = 1'b0;
    issue(OP_ARRIVE, 20'h80000);
    issue(OP_ARRIVE, 20'd1);
    // middle entry served, younger ones close the gap
    issue(OP_HIGHEST, '0);
    issue(OP_OLDEST, '0);
    issue(OP_OLDEST, '0);
    issue(OP_OLDEST, '0);

    // random phases with different arrival mixes; the first one is arrival
    // heavy and long enough to fill the pool and hit dropped arrivals
    first_phase = 1'b1;
    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if (first_phase) begin
        arrive_pct = 95;
        phase_len = 100;
        first_phase = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: arrive_pct = 95;
          1: arrive_pct = 50;
          default: arrive_pct = 10;
        endcase
        phase_len = $urandom_range(30, 90);
      end
      // last phase stops at the item target
      if (phase_len > ITEM_TARGET - sent) phase_len = ITEM_TARGET - sent;
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < arrive_pct) begin
          op = OP_ARRIVE;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: op = OP_OLDEST;
            5, 6, 7, 8: op = OP_HIGHEST;
            default: op = OP_HIGHEST_ALIAS;
          endcase
        end
        // serves get a random amount too, the block must ignore it
        issue(op, pick_amount());
      end
    end
    start <= 1'b0;

    // drain: replies_due is registered, so it lags the reply queue; then leave room for a stray beat
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && replies_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
